### rtl/core/triangle_plane_clipper_assert.svh
// triangle_plane_clipper_assert.svh: assertion macros for the triangle plane clipper.
// No dependencies; included by the modules that check their own control logic.
`ifndef TRIANGLE_PLANE_CLIPPER_ASSERT_SVH
`define TRIANGLE_PLANE_CLIPPER_ASSERT_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define TPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tpc: same-cycle check failed");

// The consequent must hold at the clock edge after the antecedent.
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tpc: next-cycle check failed");

`endif

### rtl/core/tpc_pkg.sv
// tpc_pkg: shared constants and types of the triangle plane clipper.
// No dependencies; imported by tpc_front, tpc_back, the top level and the bench.
package tpc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;

	// Number of vertices on the inside of the plane.
	localparam logic [1:0] IN_NONE = 2'd0;
	localparam logic [1:0] IN_ONE  = 2'd1;
	localparam logic [1:0] IN_TWO  = 2'd2;
	localparam logic [1:0] IN_ALL  = 2'd3;

	// Classification of one triangle: inside count and vertex order.
	typedef struct packed {
		logic [1:0] o1;
		logic [1:0] o0;
		logic [1:0] i1;
		logic [1:0] i0;
		logic [1:0] n_in;
	} tpc_cls_t;

endpackage

### rtl/core/tpc_front.sv
// tpc_front: accepts triangle words, computes the three plane distances and classifies them.
// Depends on tpc_pkg; feeds tpc_queue.
module tpc_front #(
	parameter int COORD_WIDTH = 32,
	localparam int IN_W = ((9 * COORD_WIDTH + 32 + 7) / 8) * 8,
	localparam int ENT_W = 9 * COORD_WIDTH + 3 * (2 * COORD_WIDTH + 2) + 32
		+ $bits(tpc_pkg::tpc_cls_t)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, face_id, face_colour
	input  logic [IN_W-1:0]                s_tdata,
	input  logic [2:0][COORD_WIDTH-1:0]    plane_point,
	input  logic [2:0][COORD_WIDTH-1:0]    plane_normal,
	output logic                           push_valid,
	input  logic                           push_ready,
	output logic [ENT_W-1:0]               push_data
);
	import tpc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;
	localparam int DW = 2 * CW + 2;

	logic en;
	logic vld_s1, vld_s2, vld_s3;
	logic signed [PW-1:0] prod_s1 [9];
	logic signed [PW-1:0] pp_s1 [3];
	logic [9*CW-1:0] crd_s1, crd_s2, crd_s3;
	logic [31:0] tag_s1, tag_s2, tag_s3;
	logic signed [DW-1:0] dot_s2 [3];
	logic signed [DW-1:0] npd_s2;
	logic [2:0][DW-1:0] dist_s3;
	tpc_cls_t cls;
	logic [1:0] n_in, n_out;

	// The whole pipe moves together unless the last stage is stuck.
	assign en = !vld_s3 || push_ready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage one takes the products, stage two the dot sums, stage three the distances.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int v = 0; v < 3; v++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[3*v+j] <= PW'($signed(s_tdata[(3*v+j)*CW +: CW]))
						* PW'($signed(plane_normal[j]));
				end
			end
			for (int j = 0; j < 3; j++) begin
				pp_s1[j] <= PW'($signed(plane_point[j])) * PW'($signed(plane_normal[j]));
			end
			crd_s1 <= s_tdata[9*CW-1:0];
			tag_s1 <= s_tdata[9*CW +: 32];

			for (int v = 0; v < 3; v++) begin
				dot_s2[v] <= DW'(prod_s1[3*v]) + DW'(prod_s1[3*v+1]) + DW'(prod_s1[3*v+2]);
			end
			npd_s2 <= DW'(pp_s1[0]) + DW'(pp_s1[1]) + DW'(pp_s1[2]);
			crd_s2 <= crd_s1;
			tag_s2 <= tag_s1;

			for (int v = 0; v < 3; v++) begin
				dist_s3[v] <= dot_s2[v] - npd_s2;
			end
			crd_s3 <= crd_s2;
			tag_s3 <= tag_s2;
		end
	end

	// A vertex is inside when its distance is not negative; list inside and outside in order.
	always_comb begin
		cls = '0;
		n_in = '0;
		n_out = '0;
		for (int v = 0; v < 3; v++) begin
			if (!dist_s3[v][DW-1]) begin
				if (n_in == 2'd0) cls.i0 = 2'(v);
				else cls.i1 = 2'(v);
				n_in = n_in + 2'd1;
			end else begin
				if (n_out == 2'd0) cls.o0 = 2'(v);
				else cls.o1 = 2'(v);
				n_out = n_out + 2'd1;
			end
		end
		cls.n_in = n_in;
	end

	assign push_valid = vld_s3;
	assign push_data = {cls, tag_s3, dist_s3, crd_s3};

endmodule

### rtl/core/tpc_queue.sv
// tpc_queue: two-entry queue between the classifying front and the clipping back.
// No package dependency; uses the assertion macros header.
`include "triangle_plane_clipper_assert.svh"

module tpc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int DEPTH = 2;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic push_fire, pop_fire;

	assign push_ready = count_q != 2'(DEPTH);
	assign pop_valid = count_q != 2'd0;
	assign pop_data = slot_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push_fire) wr_ptr_q <= !wr_ptr_q;
			if (pop_fire) rd_ptr_q <= !rd_ptr_q;
			if (push_fire && !pop_fire) count_q <= count_q + 2'd1;
			else if (pop_fire && !push_fire) count_q <= count_q - 2'd1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_fire) slot_q[wr_ptr_q] <= push_data;
	end

	`TPC_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= 2'(DEPTH))
	`TPC_ASSERT_NEXT(a_count_grows, clk, arst_n, push_fire && !pop_fire, count_q == $past(count_q) + 2'd1)
	`TPC_ASSERT_NEXT(a_count_drops, clk, arst_n, pop_fire && !push_fire, count_q == $past(count_q) - 2'd1)

endmodule

### rtl/core/tpc_xdiv.sv
// tpc_xdiv: one axis of an edge crossing, vi + (vo - vi) * di / den rounded to nearest.
// No dependencies; one quotient bit per cycle, instantiated six times by tpc_back.
module tpc_xdiv #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [COORD_WIDTH-1:0]     vi,
	input  logic [COORD_WIDTH-1:0]     vo,
	input  logic [2*COORD_WIDTH+1:0]   di,
	input  logic [2*COORD_WIDTH+1:0]   den,
	output logic                       done,
	output logic [COORD_WIDTH-1:0]     res
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = 2 * CW + 2;
	localparam int CNT_W = $clog2(CW + 2);

	logic [CNT_W-1:0] cnt_q;
	logic [CW:0] mag_q, quo_q, qr;
	logic neg_q;
	logic [DW-1:0] rem_q, di_q, den_q;
	logic [CW-1:0] vi_q;
	logic signed [CW:0] diff;
	logic [DW+1:0] acc, acc_n, den1, den2;
	logic [1:0] inc;
	logic rnd;

	assign diff = (CW+1)'($signed(vo)) - (CW+1)'($signed(vi));

	// One step of |vo - vi| * di / den: shift in a multiplier bit, subtract den up to twice.
	always_comb begin
		acc = {1'b0, rem_q, 1'b0} + (mag_q[CW] ? (DW+2)'(di_q) : (DW+2)'(0));
		den1 = (DW+2)'(den_q);
		den2 = {1'b0, den_q, 1'b0};
		if (acc >= den2) begin
			acc_n = acc - den2;
			inc = 2'd2;
		end else if (acc >= den1) begin
			acc_n = acc - den1;
			inc = 2'd1;
		end else begin
			acc_n = acc;
			inc = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(CW + 1);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
			neg_q <= diff[CW];
			rem_q <= '0;
			quo_q <= '0;
			vi_q <= vi;
			di_q <= di;
			den_q <= den;
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[CW-1:0], 1'b0};
			rem_q <= acc_n[DW-1:0];
			quo_q <= {quo_q[CW-1:0], 1'b0} + (CW+1)'(inc);
		end
	end

	// Round half away from zero, then step from the inside vertex.
	assign rnd = {rem_q, 1'b0} >= {1'b0, den_q};
	assign qr = quo_q + (CW+1)'(rnd);
	assign res = vi_q + (neg_q ? -qr[CW-1:0] : qr[CW-1:0]);
	assign done = cnt_q == '0;

endmodule

### rtl/core/tpc_back.sv
// tpc_back: takes classified triangles from the queue and emits zero, one or two words.
// Depends on tpc_pkg and tpc_xdiv; uses the assertion macros header.
`include "triangle_plane_clipper_assert.svh"

module tpc_back #(
	parameter int COORD_WIDTH = 32,
	localparam int OUT_W = ((9 * COORD_WIDTH + 32 + 7) / 8) * 8,
	localparam int ENT_W = 9 * COORD_WIDTH + 3 * (2 * COORD_WIDTH + 2) + 32
		+ $bits(tpc_pkg::tpc_cls_t)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENT_W-1:0]   pop_data,
	output logic               m_tvalid,
	input  logic               m_tready,
	// out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
	// out_c_x, out_c_y, out_c_z, out_id, out_colour
	output logic [OUT_W-1:0]   m_tdata,
	// last_piece
	output logic               m_tlast
);
	import tpc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int DW = 2 * CW + 2;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT0 = 2'd2;
	localparam logic [1:0] ST_OUT1 = 2'd3;

	logic [1:0] state_q, state_d;
	logic [2:0][2:0][CW-1:0] head_v, cur_v_q, nxt_tri, out_tri_q;
	logic [2:0][DW-1:0] head_dist;
	logic [31:0] head_tag, cur_tag_q, nxt_tag, out_tag_q;
	tpc_cls_t head_cls, cur_cls_q;
	logic [1:0] ci [2];
	logic [1:0] co [2];
	logic [DW-1:0] den [2];
	logic [1:0][2:0][CW-1:0] xres;
	logic [5:0] lane_done;
	logic start, load, nxt_last, out_free, pop_fire;
	logic m_tvalid_q, m_tlast_q;

	// Unpack the queue head.
	assign head_v = pop_data[9*CW-1:0];
	assign head_dist = pop_data[9*CW +: 3*DW];
	assign head_tag = pop_data[9*CW+3*DW +: 32];
	assign head_cls = tpc_cls_t'(pop_data[9*CW+3*DW+32 +: $bits(tpc_cls_t)]);

	// Edges to cut: one inside vertex cuts to both outside ones, two inside cut to the one.
	always_comb begin
		ci[0] = head_cls.i0;
		co[0] = head_cls.o0;
		ci[1] = (head_cls.n_in == IN_ONE) ? head_cls.i0 : head_cls.i1;
		co[1] = (head_cls.n_in == IN_ONE) ? head_cls.o1 : head_cls.o0;
		for (int c = 0; c < 2; c++) begin
			den[c] = head_dist[ci[c]] - head_dist[co[c]];
		end
	end

	// Six division lanes: two crossings by three axes.
	for (genvar c = 0; c < 2; c++) begin : g_cross
		for (genvar k = 0; k < 3; k++) begin : g_axis
			tpc_xdiv #(.COORD_WIDTH(CW)) u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (start),
				.vi     (head_v[ci[c]][k]),
				.vo     (head_v[co[c]][k]),
				.di     (head_dist[ci[c]]),
				.den    (den[c]),
				.done   (lane_done[3*c+k]),
				.res    (xres[c][k])
			);
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign pop_fire = pop_valid && pop_ready;

	// Sequencer: pass, drop or clip the head, then hand out the pieces.
	always_comb begin
		state_d = state_q;
		pop_ready = 1'b0;
		start = 1'b0;
		load = 1'b0;
		nxt_tri = head_v;
		nxt_tag = head_tag;
		nxt_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					unique case (head_cls.n_in)
						IN_NONE: pop_ready = 1'b1;
						IN_ALL: begin
							pop_ready = out_free;
							load = out_free;
						end
						default: begin
							pop_ready = 1'b1;
							start = 1'b1;
							state_d = ST_DIV;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (lane_done[0]) state_d = ST_OUT0;
			end
			ST_OUT0: begin
				nxt_tag = cur_tag_q;
				nxt_tri[0] = cur_v_q[cur_cls_q.i0];
				if (cur_cls_q.n_in == IN_ONE) begin
					nxt_tri[1] = xres[0];
					nxt_tri[2] = xres[1];
				end else begin
					nxt_tri[1] = cur_v_q[cur_cls_q.i1];
					nxt_tri[2] = xres[0];
					nxt_last = 1'b0;
				end
				if (out_free) begin
					load = 1'b1;
					state_d = (cur_cls_q.n_in == IN_ONE) ? ST_IDLE : ST_OUT1;
				end
			end
			ST_OUT1: begin
				nxt_tag = cur_tag_q;
				nxt_tri[0] = cur_v_q[cur_cls_q.i1];
				nxt_tri[1] = xres[0];
				nxt_tri[2] = xres[1];
				if (out_free) begin
					load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Held triangle for the clip and the output word register.
	always_ff @(posedge clk) begin
		if (start) begin
			cur_v_q <= head_v;
			cur_tag_q <= head_tag;
			cur_cls_q <= head_cls;
		end
		if (load) begin
			out_tri_q <= nxt_tri;
			out_tag_q <= nxt_tag;
			m_tlast_q <= nxt_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = OUT_W'({out_tag_q, out_tri_q});

	`TPC_ASSERT_NOW(a_lanes_in_step, clk, arst_n, 1'b1, lane_done == 6'b000000 || lane_done == 6'b111111)
	`TPC_ASSERT_NEXT(a_pass_loads, clk, arst_n, pop_fire && head_cls.n_in == IN_ALL, m_tvalid_q)
	`TPC_ASSERT_NOW(a_first_piece, clk, arst_n, m_tvalid_q && !m_tlast_q, state_q == ST_OUT1)

endmodule

### rtl/core/triangle_plane_clipper.sv
// triangle_plane_clipper: top level, plane registers plus front, queue and back.
// Depends on tpc_pkg, tpc_front, tpc_queue and tpc_back.
//
// Clips one triangle word against the plane held in the six configuration registers and
// sends out zero, one or two triangle words; m_tlast marks the last word of each input.
// A triangle that lies wholly inside or wholly outside needs no division in the back part,
// so such triangles stream at one per cycle while the output is not stalled. A triangle that
// crosses the plane holds the back part, which takes no new triangle, while six long-division
// lanes produce one quotient bit per cycle each; then its one or two pieces leave through
// the output register one per cycle while the receiver is ready. A two-entry queue lets the
// front keep accepting while the back works. There is no clearing pass after reset.
module triangle_plane_clipper #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16,
	localparam int DATA_W = ((9 * COORD_WIDTH + 32 + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
	// vertex_c_x, vertex_c_y, vertex_c_z, face_id, face_colour
	input  logic [DATA_W-1:0]                s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_a_x, out_a_y, out_a_z, out_b_x, out_b_y, out_b_z,
	// out_c_x, out_c_y, out_c_z, out_id, out_colour
	output logic [DATA_W-1:0]                m_tdata,
	// last_piece
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]           cfg_data
);
	import tpc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int ENT_W = 9 * CW + 3 * (2 * CW + 2) + 32 + $bits(tpc_cls_t);

	logic [2:0][CW-1:0] point_q, normal_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	logic [ENT_W-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;

	// Plane registers; indexes past the normal are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= '0;
			normal_q[0] <= '0;
			normal_q[1] <= '0;
			normal_q[2] <= CW'(64'd1 << FRAC_BITS);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POINT_X: point_q[0] <= cfg_data;
				REG_POINT_Y: point_q[1] <= cfg_data;
				REG_POINT_Z: point_q[2] <= cfg_data;
				REG_NORMAL_X: normal_q[0] <= cfg_data;
				REG_NORMAL_Y: normal_q[1] <= cfg_data;
				REG_NORMAL_Z: normal_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	tpc_front #(.COORD_WIDTH(CW)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.plane_point  (point_q),
		.plane_normal (normal_q),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_data    (push_data)
	);

	tpc_queue #(.WIDTH(ENT_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tpc_back #(.COORD_WIDTH(CW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### bench/triangle_plane_clipper_test.sv
// triangle_plane_clipper_test: self-checking bench for the triangle plane clipper.
// Depends on tpc_pkg and triangle_plane_clipper; predicts every output triangle word.
`timescale 1ns / 1ps

module triangle_plane_clipper_test;
	import tpc_pkg::*;

	localparam int CW = 32;
	localparam int DATA_W = 320;
	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT = 5000;

	// One triangle word; coordinates a.xyz, b.xyz, c.xyz from the lowest bits up.
	typedef struct packed {
		logic [15:0]         colour;
		logic [15:0]         id;
		logic [8:0][CW-1:0]  coord;
	} tri_word_t;

	typedef struct packed {
		logic       last;
		tri_word_t  body;
	} piece_t;

	// Wide signed type for exact distances and crossing quotients.
	typedef logic signed [159:0] wide_t;
	typedef logic [2:0][CW-1:0] vertex_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0] cfg_data;

	// Plane registers as the block should hold them: point then normal.
	logic [CW-1:0] plane_point [3];
	logic [CW-1:0] plane_normal [3];

	piece_t expected_pieces [$];
	int errors = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_cycles = 0;
	string coord_name [9] = '{"out_a_x", "out_a_y", "out_a_z", "out_b_x", "out_b_y",
		"out_b_z", "out_c_x", "out_c_y", "out_c_z"};

	triangle_plane_clipper u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Receiver readiness with random stalls.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Compare each accepted output word with the oldest expected piece.
	always @(posedge clk) begin
		piece_t want;
		tri_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_pieces.size() == 0) begin
				$error("unexpected output word: %h", m_tdata);
				errors++;
			end else begin
				want = expected_pieces.pop_front();
				for (int k = 0; k < 9; k++)
					if (got.coord[k] !== want.body.coord[k]) begin
						$error("%s expected %h actual %h", coord_name[k],
							want.body.coord[k], got.coord[k]);
						errors++;
					end
				if (got.id !== want.body.id) begin
					$error("out_id expected %h actual %h", want.body.id, got.id);
					errors++;
				end
				if (got.colour !== want.body.colour) begin
					$error("out_colour expected %h actual %h", want.body.colour, got.colour);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_piece expected %b actual %b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("triangle_plane_clipper test failed");
			$finish;
		end
	end

	function automatic wide_t widen(logic [CW-1:0] x);
		return wide_t'($signed(x));
	endfunction

	function automatic wide_t plane_dot(vertex_t v);
		return widen(plane_normal[0]) * widen(v[0]) + widen(plane_normal[1]) * widen(v[1])
			+ widen(plane_normal[2]) * widen(v[2]);
	endfunction

	// Point where edge inside->outside meets the plane, rounded half away from zero.
	function automatic vertex_t edge_crossing(vertex_t vi, vertex_t vo, wide_t di, wide_t dout);
		vertex_t res;
		wide_t den;
		wide_t num;
		wide_t mag;
		wide_t quo;
		den = di - dout;
		for (int k = 0; k < 3; k++) begin
			num = (widen(vo[k]) - widen(vi[k])) * di;
			mag = (num < 0) ? -num : num;
			quo = (2 * mag + den) / (2 * den);
			res[k] = vi[k] + ((num < 0) ? -quo[CW-1:0] : quo[CW-1:0]);
		end
		return res;
	endfunction

	function automatic piece_t make_piece(vertex_t a, vertex_t b, vertex_t c,
			tri_word_t t, logic last);
		piece_t p;
		p.last = last;
		p.body.id = t.id;
		p.body.colour = t.colour;
		p.body.coord = {c, b, a};
		return p;
	endfunction

	// Append one piece at the tail of the expected list.
	function automatic void queue_piece(piece_t p);
		expected_pieces.insert(expected_pieces.size(), p);
	endfunction

	// Classify the vertices and queue the pieces the clipper must produce.
	function automatic void predict_clip(tri_word_t t);
		vertex_t v [3];
		wide_t d [3];
		wide_t np;
		int ins [3];
		int outs [3];
		int n_ins;
		int n_outs;
		vertex_t x0;
		vertex_t x1;
		n_ins = 0;
		n_outs = 0;
		np = widen(plane_normal[0]) * widen(plane_point[0])
			+ widen(plane_normal[1]) * widen(plane_point[1])
			+ widen(plane_normal[2]) * widen(plane_point[2]);
		for (int k = 0; k < 3; k++) begin
			v[k] = t.coord[k*3 +: 3];
			d[k] = plane_dot(v[k]) - np;
			if (d[k] < 0) begin
				outs[n_outs] = k;
				n_outs++;
			end else begin
				ins[n_ins] = k;
				n_ins++;
			end
		end
		if (n_ins == 3) begin
			queue_piece(make_piece(v[0], v[1], v[2], t, 1'b1));
		end else if (n_ins == 1) begin
			x0 = edge_crossing(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
			x1 = edge_crossing(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]]);
			queue_piece(make_piece(v[ins[0]], x0, x1, t, 1'b1));
		end else if (n_ins == 2) begin
			x0 = edge_crossing(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
			x1 = edge_crossing(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]]);
			queue_piece(make_piece(v[ins[0]], v[ins[1]], x0, t, 1'b0));
			queue_piece(make_piece(v[ins[1]], x0, x1, t, 1'b1));
		end
	endfunction

	// Send one triangle word, sometimes with a random gap before it.
	task automatic send_triangle(tri_word_t t);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		predict_clip(t);
	endtask

	// Writes one register; the caller lowers cfg_valid after its last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_POINT_Z) plane_point[idx] = val;
		else if (idx <= REG_NORMAL_Z) plane_normal[idx - REG_NORMAL_X] = val;
	endtask

	// Wait until every expected word is in, then let the back part settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_pieces.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_plane(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
			logic [CW-1:0] nx, logic [CW-1:0] ny, logic [CW-1:0] nz);
		drain();
		write_reg(REG_POINT_X, px);
		write_reg(REG_POINT_Y, py);
		write_reg(REG_POINT_Z, pz);
		write_reg(REG_NORMAL_X, nx);
		write_reg(REG_NORMAL_Y, ny);
		write_reg(REG_NORMAL_Z, nz);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic tri_word_t build_tri(vertex_t a, vertex_t b, vertex_t c,
			logic [15:0] id, logic [15:0] colour);
		tri_word_t t;
		t.coord = {c, b, a};
		t.id = id;
		t.colour = colour;
		return t;
	endfunction

	function automatic vertex_t vtx(int x, int y, int z);
		return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
	endfunction

	// Coordinates mostly near the origin so edges cross the plane, sometimes full range.
	function automatic logic [CW-1:0] rand_coord(bit full);
		logic [31:0] r;
		r = $urandom;
		return full ? r : {{11{r[20]}}, r[20:0]};
	endfunction

	function automatic tri_word_t rand_tri();
		tri_word_t t;
		bit full;
		full = ($urandom_range(99) < 25);
		for (int k = 0; k < 9; k++) t.coord[k] = rand_coord(full);
		t.id = 16'($urandom);
		t.colour = 16'($urandom);
		return t;
	endfunction

	// Reset plane z >= 0: every inside count, on-plane and degenerate cases.
	task automatic test_reset_plane();
		send_triangle(build_tri(vtx(1, 2, 3), vtx(-4, 5, 6), vtx(7, -8, 9), 16'h0000, 16'h0000));
		send_triangle(build_tri(vtx(1, 2, -3), vtx(4, 5, -6), vtx(7, 8, -9), 16'hffff, 16'hffff));
		send_triangle(build_tri(vtx(0, 0, 65536), vtx(65536, 0, -65536),
			vtx(0, 65536, -131072), 16'h1234, 16'h5678));
		send_triangle(build_tri(vtx(0, 0, -65536), vtx(65536, 0, 65536),
			vtx(0, 65536, 3), 16'habcd, 16'h0f0f));
		send_triangle(build_tri(vtx(5, 5, 0), vtx(9, 1, 0), vtx(3, 3, -7), 16'h0001, 16'h8000));
		send_triangle(build_tri(vtx(5, 5, 5), vtx(5, 5, 5), vtx(5, 5, -5), 16'h0002, 16'h0003));
		send_triangle(build_tri(vtx(3, 1, 1), vtx(-2, 1, -1), vtx(7, 7, -2), 16'h0004, 16'h0005));
		send_triangle(build_tri(vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff),
			vtx(32'h80000000, 32'h7fffffff, 32'h80000000),
			vtx(32'h7fffffff, 32'h7fffffff, 32'h80000000), 16'h8000, 16'h7fff));
		send_triangle(build_tri(vtx(32'h80000000, 32'h80000000, 32'h7fffffff),
			vtx(0, 0, 32'h80000000), vtx(-1, -1, 32'h80000000), 16'hffff, 16'h0000));
	endtask

	// Zero normal, extreme normals and the unused register indexes.
	task automatic test_plane_extremes();
		set_plane(0, 0, 0, 0, 0, 0);
		write_reg(3'd6, 32'hdeadbeef);
		write_reg(3'd7, 32'h12345678);
		cfg_valid <= 1'b0;
		send_triangle(build_tri(vtx(1, 2, -3), vtx(4, 5, -6), vtx(7, 8, -9), 16'h0010, 16'h0011));
		set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000);
		send_triangle(build_tri(vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff),
			vtx(32'h80000000, 32'h7fffffff, 32'h80000000), vtx(0, 0, 0), 16'h0020, 16'h0021));
		send_triangle(rand_tri());
		set_plane(32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_triangle(build_tri(vtx(32'h80000000, 32'h80000000, 32'h80000000),
			vtx(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), vtx(0, 0, 0), 16'h0030, 16'h0031));
		send_triangle(rand_tri());
		set_plane(0, 0, 0, 65536, 65536, 0);
		send_triangle(build_tri(vtx(100, -50, 1), vtx(-100, -100, 2), vtx(-10, 300, 3),
			16'h0040, 16'h0041));
	endtask

	// Random planes and triangles under each idling pattern.
	task automatic test_random_clip();
		int idle_mix [3][2] = '{'{22, 85}, '{85, 22}, '{0, 0}};
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = idle_mix[phase][0];
			rx_idle_pct = idle_mix[phase][1];
			for (int p = 0; p < 2; p++) begin
				set_plane(rand_coord(0), rand_coord(0), rand_coord($urandom_range(3) == 0),
					rand_coord($urandom_range(1)), rand_coord($urandom_range(1)),
					rand_coord($urandom_range(1)));
				for (int n = 0; n < 170; n++) begin
					// Hold the sender off once until the output side is empty.
					if (n == 85 && p == 0) begin
						s_tvalid <= 1'b0;
						while (expected_pieces.size() != 0) @(posedge clk);
					end
					send_triangle(rand_tri());
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_POINT_X;
		cfg_data = '0;
		plane_point = '{default: '0};
		plane_normal = '{0, 0, 32'h00010000};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_plane();
		test_plane_extremes();
		test_random_clip();
		drain();
		if (errors == 0)
			$display("triangle_plane_clipper test passed");
		else
			$display("triangle_plane_clipper test failed");
		$finish;
	end

endmodule
